[hw/rtl/pwm_prescaler_period_select_defines.svh]
// Assertion macros used by the checker file of the PWM prescaler block.
// Depends on nothing; the including module must have aclk and aresetn.
`ifndef PWM_PRESCALER_PERIOD_SELECT_DEFINES_SVH
`define PWM_PRESCALER_PERIOD_SELECT_DEFINES_SVH

// Clocked assertion, switched off while reset is held
`define PPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define PPS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hw/rtl/pps_pkg.sv]
// Shared types, constants and helper functions of the PWM prescaler and
// period selector. No dependencies.
package pps_pkg;

    localparam int unsigned DATA_W            = 32;
    localparam int unsigned CODE_W            = 3;
    localparam int unsigned PERIOD_W          = 17;
    localparam int unsigned SHIFT_W           = 4;
    localparam int unsigned NUM_CODES         = 8;
    localparam int unsigned M_TDATA_W         = 24;
    localparam int unsigned TDATA_PAD_W       = M_TDATA_W - CODE_W - PERIOD_W;
    localparam int unsigned DEF_MAX_PERIOD    = 65536;
    localparam logic [DATA_W-1:0] DEF_BASE_CLOCK_HZ = 32'd120000000;
    localparam logic [CODE_W-1:0] CODE_MAX    = 3'd7;

    // One restoring-divide step: remainder, dividend/quotient shift word,
    // divisor and a flag for a zero divisor
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] dq;
        logic [DATA_W-1:0] dsr;
        logic              dsr_zero;
    } div_stage_t;

    // Right shift for each prescaler code (dividers 1,2,4,8,16,64,256,1024)
    function automatic logic [SHIFT_W-1:0] code_shift(input logic [CODE_W-1:0] code);
        logic [SHIFT_W-1:0] sh;
        case (code)
            3'd0:    sh = 4'd0;
            3'd1:    sh = 4'd1;
            3'd2:    sh = 4'd2;
            3'd3:    sh = 4'd3;
            3'd4:    sh = 4'd4;
            3'd5:    sh = 4'd6;
            3'd6:    sh = 4'd8;
            3'd7:    sh = 4'd10;
            default: sh = 4'd0;
        endcase
        return sh;
    endfunction

    // Bring down the next dividend bit, subtract the divisor if it fits
    function automatic div_stage_t div_step(input div_stage_t cur);
        div_stage_t         nxt;
        logic [DATA_W:0]    trial;
        logic [DATA_W:0]    diff;
        trial = {cur.rem, cur.dq[DATA_W-1]};
        diff  = trial - {1'b0, cur.dsr};
        nxt   = cur;
        if (!diff[DATA_W]) begin
            nxt.rem = diff[DATA_W-1:0];
        end else begin
            nxt.rem = trial[DATA_W-1:0];
        end
        nxt.dq = {cur.dq[DATA_W-2:0], ~diff[DATA_W]};
        return nxt;
    endfunction

endpackage

[hw/rtl/pwm_prescaler_period_select.sv]
// Top level of the PWM prescaler and period selector: pipelined divider
// and prescaler pick. Depends on pps_pkg.
//
//  Channel  Direction  Payload (low bit first)
//  -------  ---------  ------------------------------------------------------
//  cfg_w    in         cfg_wdata: base_clock_hz[31:0]
//  s_       in         s_tdata: target_freq_hz[31:0]
//  m_       out        m_tdata: prescale_code[2:0], period_clocks[19:3], zero pad
//                      m_tuser: range_error[0]
//
// One transaction per clock sustained while m_ is not stalled; 32 restoring-divide
// stages (one quotient bit each, a 33-bit subtract per stage) and one stage
// that picks the prescaler and drives the output register.
// Reset (aresetn low, synchronous) clears all valid bits and reloads the base
// clock register with 120 MHz; cfg_wready is always high.
// A stall on m_ holds the output; upstream stages keep filling bubbles and
// s_tready drops only when every stage holds a transaction.
module pwm_prescaler_period_select #(
    parameter int unsigned MAX_PERIOD = pps_pkg::DEF_MAX_PERIOD
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wvalid,
    output logic                          cfg_wready,
    input  logic [pps_pkg::DATA_W-1:0]    cfg_wdata,    // base_clock_hz
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pps_pkg::DATA_W-1:0]    s_tdata,      // target_freq_hz
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pps_pkg::M_TDATA_W-1:0] m_tdata,      // prescale_code, period_clocks, pad
    output logic [0:0]                    m_tuser       // range_error
);
    import pps_pkg::*;

    localparam int unsigned NUM_DIV = DATA_W;
    localparam logic [DATA_W-1:0] MAX_P = DATA_W'(MAX_PERIOD);

    logic [DATA_W-1:0]   base_clock_reg;
    div_stage_t          div_reg  [NUM_DIV];
    div_stage_t          div_next [NUM_DIV];
    logic [NUM_DIV-1:0]  vld_reg;
    logic [NUM_DIV-1:0]  vld_next;
    logic [NUM_DIV-1:0]  stg_en;
    logic                out_en;
    div_stage_t          div_in;

    logic [CODE_W-1:0]   code_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic                err_reg;
    logic                m_tvalid_reg;
    logic [CODE_W-1:0]   code_next;
    logic [PERIOD_W-1:0] period_next;
    logic                err_next;
    logic [NUM_CODES-1:0] fits;
    logic [DATA_W-1:0]   quot;
    logic [DATA_W-1:0]   sel_q;

    // Configuration register: always ready
    assign cfg_wready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_clock_reg <= DEF_BASE_CLOCK_HZ;
        end else if (cfg_wvalid && cfg_wready) begin
            base_clock_reg <= cfg_wdata;
        end
    end

    // Stage enables: a stage loads when the output is free or a bubble lies
    // at or after it
    assign out_en = !m_tvalid_reg || m_tready;

    for (genvar i = 0; i < NUM_DIV; i++) begin : g_en
        assign stg_en[i] = out_en || !(&vld_reg[NUM_DIV-1:i]);
    end

    assign s_tready = stg_en[0];

    // Divide base clock by frequency, one quotient bit per stage
    always_comb begin
        div_in.rem      = '0;
        div_in.dq       = base_clock_reg;
        div_in.dsr      = s_tdata;
        div_in.dsr_zero = (s_tdata == '0);
        div_next[0]     = div_step(div_in);
        vld_next[0]     = s_tvalid;
        for (int i = 1; i < NUM_DIV; i++) begin
            div_next[i] = div_step(div_reg[i-1]);
            vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NUM_DIV; i++) begin
                if (stg_en[i]) begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_DIV; i++) begin
            if (stg_en[i]) begin
                div_reg[i] <= div_next[i];
            end
        end
    end

    // Pick the smallest code whose shifted quotient fits the period limit
    assign quot = div_reg[NUM_DIV-1].dq;

    always_comb begin
        for (int c = 0; c < NUM_CODES; c++) begin
            fits[c] = (quot >> code_shift(CODE_W'(c))) <= MAX_P;
        end
        code_next = CODE_MAX;
        for (int c = NUM_CODES - 1; c >= 0; c--) begin
            if (fits[c]) begin
                code_next = CODE_W'(c);
            end
        end
        err_next = div_reg[NUM_DIV-1].dsr_zero || !fits[NUM_CODES-1];
        sel_q    = quot >> code_shift(code_next);
        if (err_next) begin
            code_next   = CODE_MAX;
            period_next = MAX_P[PERIOD_W-1:0];
        end else begin
            period_next = sel_q[PERIOD_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_en) begin
            m_tvalid_reg <= vld_reg[NUM_DIV-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            code_reg   <= code_next;
            period_reg <= period_next;
            err_reg    <= err_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{TDATA_PAD_W{1'b0}}, period_reg, code_reg};
    assign m_tuser  = err_reg;

endmodule

[hw/rtl/pps_checker.sv]
// Port-level checker for the PWM prescaler and period selector, with its
// bind. Depends on pps_pkg and pwm_prescaler_period_select_defines.svh.
`include "pwm_prescaler_period_select_defines.svh"

module pps_checker #(
    parameter int unsigned MAX_PERIOD = pps_pkg::DEF_MAX_PERIOD
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pps_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                    m_tuser
);
    import pps_pkg::*;

    localparam logic [DATA_W-1:0] MAX_P = DATA_W'(MAX_PERIOD);

    logic [CODE_W-1:0]   code_w;
    logic [PERIOD_W-1:0] period_w;
    logic [DATA_W-1:0]   period_ext;

    assign code_w     = m_tdata[CODE_W-1:0];
    assign period_w   = m_tdata[CODE_W+PERIOD_W-1:CODE_W];
    assign period_ext = DATA_W'(period_w);

    // Hold a stalled transaction unchanged
    `PPS_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Error results carry the largest code and the saturated period
    `PPS_ASSERT(a_err_sat, m_tvalid && m_tuser[0] |-> code_w == CODE_MAX && period_w == MAX_P[PERIOD_W-1:0], "error result not saturated")

    // Good results never exceed the period limit
    `PPS_ASSERT(a_period_fit, m_tvalid && !m_tuser[0] |-> period_ext <= MAX_P, "period above limit")

    // Drop any result during reset
    `PPS_ASSERT_RST(a_rst_idle, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind pwm_prescaler_period_select pps_checker #(.MAX_PERIOD(MAX_PERIOD)) u_pps_checker (.*);
